FILE: rtl/core/btmx_pkg.sv
`timescale 1ns / 1ps

package btmx_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned COUNT_W   = 17;
    localparam int unsigned S_TDATA_W = 72;
    localparam int unsigned M_TDATA_W = 40;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1FFFF;
    localparam logic [COUNT_W-1:0] COUNT_ONE = 17'h00001;

    typedef enum logic
    {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed
    {
        status_t             status;
        logic [DATA_W-1:0]   best_xor;
    } result_t;

    typedef enum logic [1:0]
    {
        SRC_ROOT,
        SRC_MEM,
        SRC_NEW
    } node_src_t;

    typedef enum logic [1:0]
    {
        IW_IDLE,
        IW_CHECK,
        IW_WALK,
        IW_LEAF
    } ins_state_t;

    typedef enum logic [1:0]
    {
        QW_IDLE,
        QW_FETCH,
        QW_STEP
    } qry_state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

FILE: rtl/core/btmx_node_ram.sv
`timescale 1ns / 1ps

module btmx_node_ram
#(
    parameter int unsigned DEPTH  = 65536,
    parameter int unsigned ADDR_W = 16,
    parameter int unsigned WIDTH  = 49
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr0,
    output logic [WIDTH-1:0]  rd_data0,
    input  logic [ADDR_W-1:0] rd_addr1,
    output logic [WIDTH-1:0]  rd_data1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

FILE: rtl/core/btmx_ins_walk.sv
`timescale 1ns / 1ps

module btmx_ins_walk
    import btmx_pkg::*;
#(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned NODE_COUNT = 65536,
    localparam int unsigned IDX_W     = $clog2(NODE_COUNT),
    localparam int unsigned ENTRY_W   = COUNT_W + 2 * IDX_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] key,
    input  logic [ENTRY_W-1:0]  rd_data,
    output logic [IDX_W-1:0]    rd_addr,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output logic [ENTRY_W-1:0]  wr_data,
    output logic [COUNT_W-1:0]  root_cnt,
    output logic [IDX_W-1:0]    root_kid0,
    output logic [IDX_W-1:0]    root_kid1,
    output logic                done,
    output result_t             res
);

    localparam int unsigned NFREE_W = $clog2(NODE_COUNT + 1);
    localparam int unsigned LVL_W   = $clog2(KEY_BITS);
    localparam int unsigned SUM_W   = NFREE_W + 1;

    localparam logic [SUM_W-1:0] POOL_SIZE  = SUM_W'(NODE_COUNT);
    localparam logic [SUM_W-1:0] PATH_NODES = SUM_W'(KEY_BITS);
    localparam logic [LVL_W-1:0] TOP_LVL    = LVL_W'(KEY_BITS - 1);

    ins_state_t           state_reg, state_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [IDX_W-1:0]     cur_idx_reg, cur_idx_next;
    node_src_t            src_reg, src_next;
    logic [COUNT_W-1:0]   root_cnt_reg, root_cnt_next;
    logic [IDX_W-1:0]     root_kid0_reg, root_kid0_next;
    logic [IDX_W-1:0]     root_kid1_reg, root_kid1_next;
    logic [NFREE_W-1:0]   free_reg, free_next;

    logic [COUNT_W-1:0]   cur_cnt;
    logic [COUNT_W-1:0]   cnt_inc;
    logic [IDX_W-1:0]     cur_kid0;
    logic [IDX_W-1:0]     cur_kid1;
    logic [IDX_W-1:0]     kid_b;
    logic [IDX_W-1:0]     child;
    logic [IDX_W-1:0]     new_kid0;
    logic [IDX_W-1:0]     new_kid1;
    logic                 bit_b;
    logic                 exists;
    logic [SUM_W-1:0]     need_sum;
    logic [SUM_W-1:0]     quick_sum;

    always_comb
    begin
        case (src_reg)
            SRC_ROOT:
            begin
                cur_cnt  = root_cnt_reg;
                cur_kid0 = root_kid0_reg;
                cur_kid1 = root_kid1_reg;
            end
            SRC_MEM:
            begin
                cur_cnt  = rd_data[ENTRY_W-1 -: COUNT_W];
                cur_kid1 = rd_data[2*IDX_W-1 -: IDX_W];
                cur_kid0 = rd_data[IDX_W-1:0];
            end
            default:
            begin
                cur_cnt  = '0;
                cur_kid0 = '0;
                cur_kid1 = '0;
            end
        endcase
    end

    assign bit_b     = key[lvl_reg];
    assign kid_b     = bit_b ? cur_kid1 : cur_kid0;
    assign exists    = (kid_b != '0);
    assign child     = exists ? kid_b : free_reg[IDX_W-1:0];
    assign cnt_inc   = sat_inc(cur_cnt);
    assign new_kid0  = bit_b ? cur_kid0 : child;
    assign new_kid1  = bit_b ? child : cur_kid1;
    assign need_sum  = SUM_W'(free_reg) + SUM_W'(lvl_reg) + SUM_W'(1);
    assign quick_sum = SUM_W'(free_reg) + PATH_NODES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IW_IDLE;
            lvl_reg       <= '0;
            cur_idx_reg   <= '0;
            src_reg       <= SRC_ROOT;
            root_cnt_reg  <= '0;
            root_kid0_reg <= '0;
            root_kid1_reg <= '0;
            free_reg      <= NFREE_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            cur_idx_reg   <= cur_idx_next;
            src_reg       <= src_next;
            root_cnt_reg  <= root_cnt_next;
            root_kid0_reg <= root_kid0_next;
            root_kid1_reg <= root_kid1_next;
            free_reg      <= free_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        cur_idx_next   = cur_idx_reg;
        src_next       = src_reg;
        root_cnt_next  = root_cnt_reg;
        root_kid0_next = root_kid0_reg;
        root_kid1_next = root_kid1_reg;
        free_next      = free_reg;
        rd_addr        = kid_b;
        wr_en          = 1'b0;
        wr_addr        = cur_idx_reg;
        wr_data        = {cnt_inc, new_kid1, new_kid0};
        done           = 1'b0;
        res            = '{status: STATUS_OK, best_xor: '0};

        case (state_reg)
            IW_IDLE:
            begin
                if (start)
                begin
                    lvl_next   = TOP_LVL;
                    src_next   = SRC_ROOT;
                    state_next = (quick_sum <= POOL_SIZE) ? IW_WALK : IW_CHECK;
                end
            end
            IW_CHECK:
            begin
                if (!exists)
                begin
                    if (need_sum > POOL_SIZE)
                    begin
                        done       = 1'b1;
                        res.status = STATUS_FULL;
                        state_next = IW_IDLE;
                    end
                    else
                    begin
                        state_next = IW_WALK;
                        lvl_next   = TOP_LVL;
                        src_next   = SRC_ROOT;
                    end
                end
                else if (lvl_reg == '0)
                begin
                    state_next = IW_WALK;
                    lvl_next   = TOP_LVL;
                    src_next   = SRC_ROOT;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                    src_next = SRC_MEM;
                end
            end
            IW_WALK:
            begin
                if (src_reg == SRC_ROOT)
                begin
                    root_cnt_next  = cnt_inc;
                    root_kid0_next = new_kid0;
                    root_kid1_next = new_kid1;
                end
                else
                begin
                    wr_en = 1'b1;
                end
                if (!exists)
                begin
                    free_next = free_reg + 1'b1;
                end
                cur_idx_next = child;
                src_next     = exists ? SRC_MEM : SRC_NEW;
                if (lvl_reg == '0)
                begin
                    state_next = IW_LEAF;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            IW_LEAF:
            begin
                wr_en      = 1'b1;
                wr_data    = {cnt_inc, cur_kid1, cur_kid0};
                done       = 1'b1;
                state_next = IW_IDLE;
            end
            default:
            begin
                state_next = IW_IDLE;
            end
        endcase
    end

    assign root_cnt  = root_cnt_reg;
    assign root_kid0 = root_kid0_reg;
    assign root_kid1 = root_kid1_reg;

endmodule

FILE: rtl/core/btmx_qry_walk.sv
`timescale 1ns / 1ps

module btmx_qry_walk
    import btmx_pkg::*;
#(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned NODE_COUNT = 65536,
    localparam int unsigned IDX_W     = $clog2(NODE_COUNT),
    localparam int unsigned ENTRY_W   = COUNT_W + 2 * IDX_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_BITS-1:0] probe,
    input  logic                excl,
    input  logic [KEY_BITS-1:0] ekey,
    input  logic [COUNT_W-1:0]  root_cnt,
    input  logic [IDX_W-1:0]    root_kid0,
    input  logic [IDX_W-1:0]    root_kid1,
    input  logic [ENTRY_W-1:0]  rd_data0,
    input  logic [ENTRY_W-1:0]  rd_data1,
    output logic [IDX_W-1:0]    rd_addr0,
    output logic [IDX_W-1:0]    rd_addr1,
    output logic                done,
    output result_t             res
);

    localparam int unsigned LVL_W = $clog2(KEY_BITS);
    localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(KEY_BITS - 1);

    qry_state_t           state_reg, state_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [IDX_W-1:0]     qk0_reg, qk0_next;
    logic [IDX_W-1:0]     qk1_reg, qk1_next;
    logic                 match_reg, match_next;
    logic [KEY_BITS-1:0]  ans_reg, ans_next;

    logic                 bit_p;
    logic                 bit_e;
    logic [IDX_W-1:0]     other;
    logic [IDX_W-1:0]     same;
    logic [IDX_W-1:0]     nx;
    logic [COUNT_W-1:0]   oth_cnt;
    logic                 match_step;
    logic                 take_other;
    logic                 pick;
    logic [IDX_W-1:0]     nx_kid0;
    logic [IDX_W-1:0]     nx_kid1;
    logic [KEY_BITS-1:0]  ans_step;

    assign bit_p   = probe[lvl_reg];
    assign bit_e   = ekey[lvl_reg];
    assign other   = bit_p ? qk0_reg : qk1_reg;
    assign same    = bit_p ? qk1_reg : qk0_reg;
    assign oth_cnt = bit_p ? rd_data0[ENTRY_W-1 -: COUNT_W] : rd_data1[ENTRY_W-1 -: COUNT_W];

    always_comb
    begin
        match_step = match_reg;
        take_other = 1'b0;
        if (other != '0)
        begin
            if (bit_e == bit_p)
            begin
                match_step = 1'b0;
            end
            if (match_step && (oth_cnt == COUNT_ONE))
            begin
                match_step = 1'b0;
            end
            else
            begin
                take_other = 1'b1;
            end
        end
        else if (bit_e != bit_p)
        begin
            match_step = 1'b0;
        end
        ans_step          = ans_reg;
        ans_step[lvl_reg] = take_other;
    end

    assign pick    = take_other ^ bit_p;
    assign nx      = take_other ? other : same;
    assign nx_kid0 = pick ? rd_data1[IDX_W-1:0] : rd_data0[IDX_W-1:0];
    assign nx_kid1 = pick ? rd_data1[2*IDX_W-1 -: IDX_W] : rd_data0[2*IDX_W-1 -: IDX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= QW_IDLE;
            lvl_reg   <= '0;
            qk0_reg   <= '0;
            qk1_reg   <= '0;
            match_reg <= 1'b0;
            ans_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
            qk0_reg   <= qk0_next;
            qk1_reg   <= qk1_next;
            match_reg <= match_next;
            ans_reg   <= ans_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        qk0_next   = qk0_reg;
        qk1_next   = qk1_reg;
        match_next = match_reg;
        ans_next   = ans_reg;
        rd_addr0   = qk0_reg;
        rd_addr1   = qk1_reg;
        done       = 1'b0;
        res        = '{status: STATUS_OK, best_xor: '0};

        case (state_reg)
            QW_IDLE:
            begin
                if (start)
                begin
                    if (root_cnt == '0)
                    begin
                        done       = 1'b1;
                        res.status = STATUS_EMPTY;
                    end
                    else if (excl && (root_cnt == COUNT_ONE))
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        qk0_next   = root_kid0;
                        qk1_next   = root_kid1;
                        lvl_next   = TOP_LVL;
                        match_next = excl;
                        ans_next   = '0;
                        state_next = QW_FETCH;
                    end
                end
            end
            QW_FETCH:
            begin
                state_next = QW_STEP;
            end
            QW_STEP:
            begin
                rd_addr0   = nx_kid0;
                rd_addr1   = nx_kid1;
                qk0_next   = nx_kid0;
                qk1_next   = nx_kid1;
                match_next = match_step;
                ans_next   = ans_step;
                if ((nx == '0) || (lvl_reg == '0))
                begin
                    done         = 1'b1;
                    res.best_xor = DATA_W'(ans_step);
                    state_next   = QW_IDLE;
                end
                else
                begin
                    lvl_next = lvl_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = QW_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/binary_trie_max_xor_exclude_core.sv
`timescale 1ns / 1ps

// Counted binary trie with a maximum-xor query that may skip one stored copy of a key.
// Words arrive on the s_ channel: s_tuser carries the opcode (insert or query) and
// s_tdata the key or probe, the exclusion flag and the excluded key. One result word
// leaves on the m_ channel for every accepted word: best_xor and a status code.
// The trie nodes live in one node memory with a registered read; each item walks one
// level of the trie per cycle. For an insert or a query, s_tready stays low while the
// word is walked and rises with m_tvalid when the result enters the output register,
// so the block takes no new word before it is through with the last one.
// When fewer than KEY_BITS free nodes remain, an insert first walks the existing path to
// check that the pool can hold it.
// A query on an empty trie, or with exclusion on and a single stored key, has its result
// from the idle state of the query walker without walking the trie.
// Reset empties the trie at once; there is no clearing pass, as only allocated nodes
// are read.
// The result sits in an output register, so a new word is taken while the receiver stalls;
// a second finished result waits in a holding register and input stops until it drains.

module binary_trie_max_xor_exclude_core
    import btmx_pkg::*;
#(
    parameter int unsigned KEY_BITS   = 32,
    parameter int unsigned NODE_COUNT = 65536
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key_or_probe [31:0], exclude_valid [32], exclude_key [64:33], zero fill [71:65]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // best_xor [31:0], status [33:32], zero fill [39:34]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned IDX_W   = $clog2(NODE_COUNT);
    localparam int unsigned ENTRY_W = COUNT_W + 2 * IDX_W;

    logic [DATA_W-1:0]   key_reg;
    logic                excl_reg;
    logic [DATA_W-1:0]   ekey_reg;
    opcode_t             op_reg;

    logic                busy_reg, busy_next;
    logic                start_reg, start_next;
    logic                pend_reg, pend_next;
    result_t             pend_res_reg, pend_res_next;
    logic                m_valid_reg, m_valid_next;
    result_t             m_res_reg, m_res_next;

    logic                accept;
    logic                out_free;
    logic                done;
    result_t             done_res;

    logic                ins_start;
    logic                qry_start;
    logic                ins_done;
    logic                qry_done;
    result_t             ins_res;
    result_t             qry_res;

    logic [IDX_W-1:0]    ins_rd_addr;
    logic [IDX_W-1:0]    qry_rd_addr0;
    logic [IDX_W-1:0]    qry_rd_addr1;
    logic [IDX_W-1:0]    rd_addr0;
    logic [ENTRY_W-1:0]  rd_data0;
    logic [ENTRY_W-1:0]  rd_data1;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]  wr_data;

    logic [COUNT_W-1:0]  root_cnt;
    logic [IDX_W-1:0]    root_kid0;
    logic [IDX_W-1:0]    root_kid1;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = !busy_reg && !pend_reg;
    assign ins_start = start_reg && (op_reg == OP_INSERT);
    assign qry_start = start_reg && (op_reg == OP_QUERY);
    assign rd_addr0  = (op_reg == OP_INSERT) ? ins_rd_addr : qry_rd_addr0;
    assign done      = ins_done || qry_done;
    assign done_res  = ins_done ? ins_res : qry_res;
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= s_tdata[DATA_W-1:0];
            excl_reg <= s_tdata[DATA_W];
            ekey_reg <= s_tdata[2*DATA_W:DATA_W+1];
            op_reg   <= opcode_t'(s_tuser);
        end
        pend_res_reg <= pend_res_next;
        m_res_reg    <= m_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            start_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg    <= busy_next;
            start_reg   <= start_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb
    begin
        start_next    = accept;
        busy_next     = busy_reg;
        pend_next     = pend_reg;
        pend_res_next = pend_res_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_res_next    = m_res_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end

        if (out_free && pend_reg)
        begin
            m_valid_next = 1'b1;
            m_res_next   = pend_res_reg;
            pend_next    = 1'b0;
        end
        else if (out_free && done)
        begin
            m_valid_next = 1'b1;
            m_res_next   = done_res;
        end
        else if (done)
        begin
            pend_next     = 1'b1;
            pend_res_next = done_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_res_reg);

    btmx_node_ram
    #(
        .DEPTH    (NODE_COUNT),
        .ADDR_W   (IDX_W),
        .WIDTH    (ENTRY_W)
    )
    u_node_ram
    (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr0 (rd_addr0),
        .rd_data0 (rd_data0),
        .rd_addr1 (qry_rd_addr1),
        .rd_data1 (rd_data1)
    );

    btmx_ins_walk
    #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    )
    u_ins_walk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ins_start),
        .key        (KEY_BITS'(key_reg)),
        .rd_data    (rd_data0),
        .rd_addr    (ins_rd_addr),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .root_cnt   (root_cnt),
        .root_kid0  (root_kid0),
        .root_kid1  (root_kid1),
        .done       (ins_done),
        .res        (ins_res)
    );

    btmx_qry_walk
    #(
        .KEY_BITS   (KEY_BITS),
        .NODE_COUNT (NODE_COUNT)
    )
    u_qry_walk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (qry_start),
        .probe      (KEY_BITS'(key_reg)),
        .excl       (excl_reg),
        .ekey       (KEY_BITS'(ekey_reg)),
        .root_cnt   (root_cnt),
        .root_kid0  (root_kid0),
        .root_kid1  (root_kid1),
        .rd_data0   (rd_data0),
        .rd_data1   (rd_data1),
        .rd_addr0   (qry_rd_addr0),
        .rd_addr1   (qry_rd_addr1),
        .done       (qry_done),
        .res        (qry_res)
    );

    a_single_walker: assert property (@(posedge clk) disable iff (!rst_n)
        !(ins_done && qry_done))
        else $error("Both walkers finished in the same cycle.");

    a_done_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (ins_done || qry_done) |-> busy_reg)
        else $error("A walker finished with no word in flight.");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !busy_reg)
        else $error("A word was taken while a result was still held.");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (start_reg && busy_reg))
        else $error("An accepted word did not start a walk.");

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import btmx_pkg::*;

    localparam int unsigned KEY_W       = DATA_W;
    localparam int unsigned POOL        = 65536;
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    localparam int unsigned RANDOM_WORDS = 604;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef struct packed
    {
        opcode_t           op;
        logic [KEY_W-1:0]  key;
        logic              excl;
        logic [KEY_W-1:0]  ekey;
    } trie_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    trie_word_t word_backlog [$];
    result_t    xor_results_due [$];
    logic [KEY_W-1:0] stored_keys [$];

    logic [COUNT_W-1:0] node_tally [POOL];
    int unsigned        node_link [POOL][2];
    logic [COUNT_W-1:0] key_total = '0;
    int unsigned        next_node = 1;

    logic        word_fired = 1'b0;
    logic        hold_off = 1'b0;
    trie_word_t  next_word;
    trie_word_t  offered;
    result_t     forecast;
    result_t     due_word;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_span = 0;
    int unsigned run_cycles = 0;

    int unsigned words_sent = 0;
    int unsigned insert_count = 0;
    int unsigned query_count = 0;
    int unsigned excl_count = 0;
    int unsigned ok_count = 0;
    int unsigned empty_count = 0;
    int unsigned full_count = 0;
    int unsigned results_checked = 0;
    int unsigned mismatch_count = 0;

    binary_trie_max_xor_exclude_core
    #(
        .KEY_BITS   (KEY_W),
        .NODE_COUNT (POOL)
    )
    DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit link_live(int unsigned n);
        return n != 0 && n < POOL;
    endfunction

    function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic status_t trie_insert(logic [KEY_W-1:0] key);
        int unsigned node;
        int unsigned nx;
        int unsigned need;
        bit          ended;
        int          i;
        node  = 0;
        need  = 0;
        ended = 1'b0;
        for (i = KEY_W - 1; i >= 0; i--)
        begin
            if (!ended)
            begin
                nx = node_link[node][key[i]];
                if (!link_live(nx))
                begin
                    need  = i + 1;
                    ended = 1'b1;
                end
                else
                begin
                    node = nx;
                end
            end
        end
        if (next_node + need > POOL)
            return STATUS_FULL;
        key_total     = bump(key_total);
        node_tally[0] = key_total;
        node = 0;
        for (i = KEY_W - 1; i >= 0; i--)
        begin
            nx = node_link[node][key[i]];
            if (!link_live(nx))
            begin
                nx = next_node;
                next_node++;
                node_tally[nx]        = '0;
                node_link[nx][0]      = 0;
                node_link[nx][1]      = 0;
                node_link[node][key[i]] = nx;
            end
            node = nx;
            node_tally[node] = bump(node_tally[node]);
        end
        return STATUS_OK;
    endfunction

    // The walk prefers the branch that sets the xor bit, unless that branch holds only the
    // one copy of the excluded key that is still being followed.
    function automatic logic [KEY_W-1:0] trie_best_xor(logic [KEY_W-1:0] probe, logic excl,
                                                      logic [KEY_W-1:0] ekey);
        logic [KEY_W-1:0] acc;
        int unsigned      node;
        int unsigned      other;
        int unsigned      same;
        int unsigned      nx;
        bit               matching;
        bit               stopped;
        int               i;
        acc      = '0;
        node     = 0;
        matching = excl;
        stopped  = 1'b0;
        for (i = KEY_W - 1; i >= 0; i--)
        begin
            if (!stopped)
            begin
                other = node_link[node][!probe[i]];
                same  = node_link[node][probe[i]];
                if (link_live(other))
                begin
                    if (ekey[i] == probe[i])
                        matching = 1'b0;
                    if (matching && node_tally[other] == COUNT_ONE)
                    begin
                        matching = 1'b0;
                        nx = same;
                    end
                    else
                    begin
                        acc[i] = 1'b1;
                        nx = other;
                    end
                end
                else
                begin
                    if (ekey[i] != probe[i])
                        matching = 1'b0;
                    nx = same;
                end
                if (!link_live(nx))
                    stopped = 1'b1;
                else
                    node = nx;
            end
        end
        return acc;
    endfunction

    function automatic result_t trie_predict(trie_word_t w);
        result_t r;
        r.best_xor = '0;
        r.status   = STATUS_OK;
        if (w.op == OP_INSERT)
            r.status = trie_insert(w.key);
        else if (key_total == '0)
            r.status = STATUS_EMPTY;
        else if (!(w.excl && key_total == COUNT_ONE))
            r.best_xor = trie_best_xor(w.key, w.excl, w.ekey);
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < 50)
            $display("MISMATCH at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        run_cycles <= run_cycles + 1;
        if (run_cycles == CYCLE_LIMIT)
        begin
            $display("binary_trie_max_xor_exclude_core verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        word_fired <= rst_n && s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            offered.op   = opcode_t'(s_tuser);
            offered.key  = s_tdata[31:0];
            offered.excl = s_tdata[32];
            offered.ekey = s_tdata[64:33];
            forecast = trie_predict(offered);
            xor_results_due = {xor_results_due, forecast};
            words_sent++;
            if (offered.op == OP_INSERT)
                insert_count++;
            else
            begin
                query_count++;
                if (offered.excl)
                    excl_count++;
            end
            case (forecast.status)
                STATUS_OK:    ok_count++;
                STATUS_EMPTY: empty_count++;
                default:      full_count++;
            endcase
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || word_fired))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (word_backlog.size() != 0)
            begin
                next_word = word_backlog.pop_front();
                s_tdata  <= {7'b0, next_word.ekey, next_word.excl, next_word.key};
                s_tuser  <= next_word.op;
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(20, 200);
        end
        else
        begin
            stall_span--;
        end
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else if (stall_mode == 2)
            m_tready <= $urandom_range(0, 1);
        else if (stall_mode == 3)
            m_tready <= ($urandom_range(0, 4) == 0);
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (xor_results_due.size() == 0)
                report_mismatch($sformatf("result word %h with none due", m_tdata));
            else
            begin
                due_word = xor_results_due.pop_front();
                if (m_tdata[31:0] !== due_word.best_xor)
                    report_mismatch($sformatf("best_xor %h, due %h",
                                              m_tdata[31:0], due_word.best_xor));
                if (m_tdata[33:32] !== due_word.status)
                    report_mismatch($sformatf("status %0d, due %0d",
                                              m_tdata[33:32], due_word.status));
                if (m_tdata[M_TDATA_W-1:34] !== '0)
                    report_mismatch($sformatf("fill bits %h not zero",
                                              m_tdata[M_TDATA_W-1:34]));
                results_checked++;
            end
        end
    end

    // The receiver holds off for a long stretch so that the output and holding
    // registers fill and the block stops taking words.
    initial
    begin
        wait (words_sent >= 120);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic queue_word(opcode_t op, logic [KEY_W-1:0] key, logic excl,
                              logic [KEY_W-1:0] ekey);
        trie_word_t w;
        w.op   = op;
        w.key  = key;
        w.excl = excl;
        w.ekey = ekey;
        word_backlog = {word_backlog, w};
        if (op == OP_INSERT)
            stored_keys = {stored_keys, key};
    endtask

    function automatic logic [KEY_W-1:0] any_stored();
        if (stored_keys.size() == 0)
            return $urandom;
        return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    endfunction

    function automatic logic [KEY_W-1:0] nearby(logic [KEY_W-1:0] k);
        return k ^ ($urandom >> $urandom_range(8, 31));
    endfunction

    task automatic queue_random_insert();
        logic [KEY_W-1:0] key;
        case ($urandom_range(0, 9))
            0, 1, 2: key = $urandom;
            3, 4, 5: key = nearby(any_stored());
            6, 7:    key = any_stored();
            default: key = {8'($urandom_range(0, 3) * 8'h41), 24'($urandom)};
        endcase
        queue_word(OP_INSERT, key, $urandom_range(0, 1), $urandom);
    endtask

    task automatic queue_random_query();
        logic [KEY_W-1:0] probe;
        logic             excl;
        logic [KEY_W-1:0] ekey;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: probe = $urandom;
            4, 5, 6:    probe = ~any_stored();
            default:    probe = nearby(any_stored());
        endcase
        excl = ($urandom_range(0, 99) < 55);
        ekey = ($urandom_range(0, 3) != 0) ? any_stored() : $urandom;
        queue_word(OP_QUERY, probe, excl, ekey);
    endtask

    task automatic settle();
        @(posedge clk);
        #1;
    endtask

    task automatic wait_drained();
        do
            settle();
        while (word_backlog.size() != 0 || s_tvalid || xor_results_due.size() != 0);
    endtask

    initial
    begin
        int unsigned n;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_word(OP_QUERY,  32'h0000_0000, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_word(OP_INSERT, 32'h0000_0000, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        queue_word(OP_QUERY,  32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h1234_5678);
        queue_word(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        queue_word(OP_QUERY,  32'h0000_0000, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        queue_word(OP_QUERY,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000);
        queue_word(OP_INSERT, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        queue_word(OP_QUERY,  32'h0000_0000, 1'b1, 32'h1234_5678);
        queue_word(OP_INSERT, 32'h8000_0000, 1'b0, 32'h0000_0000);
        queue_word(OP_INSERT, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
        queue_word(OP_QUERY,  32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
        queue_word(OP_QUERY,  32'h5555_5555, 1'b0, 32'h0000_0000);
        queue_word(OP_INSERT, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'h5555_5555, 1'b1, 32'hAAAA_AAAA);
        queue_word(OP_QUERY,  32'hAAAA_AAAA, 1'b1, 32'hAAAA_AAAA);
        queue_word(OP_INSERT, 32'h0000_0001, 1'b0, 32'h0000_0000);
        queue_word(OP_QUERY,  32'h0000_0001, 1'b1, 32'h0000_0000);
        wait_drained();

        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if ($urandom_range(0, 99) < 45)
                queue_random_insert();
            else
                queue_random_query();
        end
        wait_drained();

        for (n = 0; n < 24; n++)
        begin
            if ($urandom_range(0, 1) == 0)
                queue_word(OP_INSERT, any_stored(), 1'b0, $urandom);
            else
                queue_random_query();
        end
        wait_drained();
        repeat (2 * KEY_W + 8) @(posedge clk);

        $display("Covered %0d words: %0d inserts, %0d queries (%0d excluding a key).",
                 words_sent, insert_count, query_count, excl_count);
        $display("Checked %0d results: ok %0d, empty trie %0d, pool full %0d; %0d nodes used.",
                 results_checked, ok_count, empty_count, full_count, next_node);
        if (mismatch_count == 0)
            $display("binary_trie_max_xor_exclude_core verification clean");
        else
            $display("binary_trie_max_xor_exclude_core verification failed");
        $finish;
    end

endmodule
